>>> rtl/tak_pkg.sv
// ----------------------------------------------------------------------------
// tak_pkg
// Shared types, operation codes and saturation helper for the tilt filter.
// ----------------------------------------------------------------------------
package tak_pkg;

  // Multiply-accumulate operations issued by the sequencer, in order
  typedef enum logic [3:0] {
    OP_ANG_PRED,
    OP_P00_PRED,
    OP_P01_PRED,
    OP_P10_PRED,
    OP_P11_PRED,
    OP_P00_CORR,
    OP_P01_CORR,
    OP_P10_CORR,
    OP_P11_CORR,
    OP_ANG_CORR,
    OP_BIAS_CORR
  } op_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_INTERVAL    = 2'd3;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] acc;
    logic               neg;
  } mac_req_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic [31:0]        den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/tak_mac.sv
// ----------------------------------------------------------------------------
// tak_mac
// Shared multiplier with rounding, accumulate and 32-bit saturation.
// ----------------------------------------------------------------------------
module tak_mac
  import tak_pkg::*;
#(
  parameter int FRAC = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mac_req_t           req,
  output logic signed [31:0] res,
  output logic               done
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC - 1);

  logic signed [63:0] prod_r;
  logic signed [31:0] acc_r;
  logic               neg_r;
  logic               v1_r;
  logic signed [31:0] res_r;
  logic               done_r;
  logic signed [63:0] rnd;
  logic signed [63:0] sum;

  always_comb begin
    rnd = (prod_r + HALF) >>> FRAC;
    sum = neg_r ? (64'(acc_r) - rnd) : (64'(acc_r) + rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      done_r <= v1_r;
    end
    if (req.start) begin
      prod_r <= req.a * req.b;
      acc_r  <= req.acc;
      neg_r  <= req.neg;
    end
    if (v1_r) begin
      res_r <= sat32(sum);
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> rtl/tak_div.sv
// ----------------------------------------------------------------------------
// tak_div
// Restoring divider for the gains: sat32((num * 2^FRAC) / den), den > 0.
// ----------------------------------------------------------------------------
module tak_div
  import tak_pkg::*;
#(
  parameter int FRAC = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic signed [31:0] quo,
  output logic               done
);

  localparam int NB = 32 + FRAC;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] dvd_r;
  logic [31:0]   rem_r;
  logic [31:0]   den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [31:0]   mag;
  logic [32:0]   rem_sh;
  logic          fits;
  logic          ovf_pos;
  logic          ovf_neg;

  always_comb begin
    mag     = req.num[31] ? 32'(-req.num) : 32'(req.num);
    rem_sh  = {rem_r, dvd_r[NB-1]};
    fits    = rem_sh >= {1'b0, den_r};
    ovf_pos = |dvd_r[NB-1:31];
    ovf_neg = (|dvd_r[NB-1:32]) || (dvd_r[31] && (|dvd_r[30:0]));
    if (neg_r) begin
      quo = ovf_neg ? -32'sh8000_0000 : -$signed(dvd_r[31:0]);
    end else begin
      quo = ovf_pos ? 32'sh7FFF_FFFF : $signed(dvd_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (req.start) begin
      dvd_r <= {mag, {FRAC{1'b0}}};
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.num[31];
    end else if (busy_r) begin
      // shift one quotient bit into the freed low end
      rem_r <= fits ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      dvd_r <= {dvd_r[NB-2:0], fits};
    end
  end

  assign done = done_r;

endmodule

>>> rtl/tilt_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter
// Two-state angle/gyro-bias Kalman filter on a shared MAC and divider.
// ----------------------------------------------------------------------------
// Usage
//   Input beat on in_valid/in_ready: measured angle Q9.16, gyro rate Q12.16.
//   Result beat: filtered angle and bias-corrected rate on out_valid/out_ready.
//   Noise and sample interval registers sit on the APB port (Q2.30); the user
//   must write them only while the filter is idle; the block does not check.
// Sequence
//   A sample runs eleven multiply-accumulates on the shared multiplier and,
//   when the innovation variance is positive, two gain divisions on the
//   bit-serial divider. One sample is in flight at a time.
// Reset
//   rst_n (synchronous) restores the register defaults, clears the estimate
//   and bias and sets the covariance to identity.
// Stalls
//   A finished result waits in the output register; a new sample is taken
//   meanwhile, and its result is held back until the previous one is taken.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter
  import tak_pkg::*;
#(
  parameter int DATA_FRAC_BITS = 16,
  parameter int COV_FRAC_BITS  = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [24:0] in_measured_angle,
  input  logic signed [27:0] in_measured_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] out_filtered_angle,
  output logic signed [27:0] out_filtered_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam longint ANG_LIM_RAW  = 64'sd180 <<< DATA_FRAC_BITS;
  localparam longint RATE_LIM_RAW = 64'sd2000 <<< DATA_FRAC_BITS;
  localparam logic signed [63:0] ANG_LIM  =
    (ANG_LIM_RAW < 64'sd16777215) ? 64'(ANG_LIM_RAW) : 64'sd16777215;
  localparam logic signed [63:0] RATE_LIM =
    (RATE_LIM_RAW < 64'sd134217727) ? 64'(RATE_LIM_RAW) : 64'sd134217727;
  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< COV_FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_ISSUE, ST_WAIT, ST_DIV_SET, ST_DIV0, ST_DIV1, ST_FINISH
  } state_t;

  state_t             state_r;
  op_t                op_r;
  logic [30:0]        qa_r, qb_r, rn_r, dt_r;
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [24:0] meas_r;
  logic signed [27:0] rate_r;
  logic signed [31:0] d_r, pd0_r, pd1_r, err_r, t0_r, t1_r, k0_r, k1_r;
  logic [31:0]        e_r;
  logic               out_valid_r;
  logic signed [24:0] out_ang_r;
  logic signed [27:0] out_rate_r;

  mac_req_t           mac_req;
  logic signed [31:0] mac_res;
  logic               mac_done;
  div_req_t           div_req;
  logic signed [31:0] div_quo;
  logic               div_done;
  logic signed [33:0] e_sum;
  logic               e_pos;
  logic signed [63:0] ang_w, rate_w;
  logic               cfg_wr;

  tak_mac #(.FRAC(COV_FRAC_BITS)) u_mac (
    .clk (clk), .rst_n (rst_n), .req (mac_req), .res (mac_res), .done (mac_done)
  );

  tak_div #(.FRAC(COV_FRAC_BITS)) u_div (
    .clk (clk), .rst_n (rst_n), .req (div_req), .quo (div_quo), .done (div_done)
  );

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_ANGLE_NOISE: prdata = {1'b0, qa_r};
      REG_BIAS_NOISE:  prdata = {1'b0, qb_r};
      REG_MEAS_NOISE:  prdata = {1'b0, rn_r};
      REG_INTERVAL:    prdata = {1'b0, dt_r};
      default:         prdata = '0;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mac_req.start = (state_r == ST_ISSUE);
    mac_req.neg   = 1'b0;
    mac_req.a     = d_r;
    mac_req.b     = $signed({1'b0, dt_r});
    mac_req.acc   = ang_r;
    case (op_r)
      OP_ANG_PRED: ;
      OP_P00_PRED: begin mac_req.a = pd0_r; mac_req.acc = p00_r; end
      OP_P01_PRED: begin mac_req.a = pd1_r; mac_req.acc = p01_r; end
      OP_P10_PRED: begin mac_req.a = pd1_r; mac_req.acc = p10_r; end
      OP_P11_PRED: begin mac_req.a = $signed({1'b0, qb_r}); mac_req.acc = p11_r; end
      OP_P00_CORR: begin
        mac_req.a = k0_r; mac_req.b = t0_r; mac_req.acc = p00_r; mac_req.neg = 1'b1;
      end
      OP_P01_CORR: begin
        mac_req.a = k0_r; mac_req.b = t1_r; mac_req.acc = p01_r; mac_req.neg = 1'b1;
      end
      OP_P10_CORR: begin
        mac_req.a = k1_r; mac_req.b = t0_r; mac_req.acc = p10_r; mac_req.neg = 1'b1;
      end
      OP_P11_CORR: begin
        mac_req.a = k1_r; mac_req.b = t1_r; mac_req.acc = p11_r; mac_req.neg = 1'b1;
      end
      OP_ANG_CORR:  begin mac_req.a = k0_r; mac_req.b = err_r; end
      OP_BIAS_CORR: begin mac_req.a = k1_r; mac_req.b = err_r; mac_req.acc = bias_r; end
      default: ;
    endcase
  end

  always_comb begin
    e_sum = $signed({3'b000, rn_r}) + 34'(p00_r);
    e_pos = (e_sum > 34'sd0);
    div_req.start = ((state_r == ST_DIV_SET) && e_pos) || ((state_r == ST_DIV0) && div_done);
    div_req.num   = (state_r == ST_DIV_SET) ? p00_r : p10_r;
    div_req.den   = (state_r == ST_DIV_SET) ? e_sum[31:0] : e_r;
    ang_w  = 64'(ang_r);
    rate_w = 64'(rate_r) - 64'(bias_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ANG_PRED;
      out_valid_r <= 1'b0;
      qa_r        <= 31'd1073742;
      qb_r        <= 31'd5368709;
      rn_r        <= 31'd536870912;
      dt_r        <= 31'd5368709;
      ang_r       <= '0;
      bias_r      <= '0;
      p00_r       <= ONE;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= ONE;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ANGLE_NOISE: qa_r <= pwdata[30:0];
          REG_BIAS_NOISE:  qb_r <= pwdata[30:0];
          REG_MEAS_NOISE:  rn_r <= pwdata[30:0];
          REG_INTERVAL:    dt_r <= pwdata[30:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r  <= in_measured_angle;
            rate_r  <= in_measured_rate;
            state_r <= ST_PRE;
          end
        end
        ST_PRE: begin
          d_r     <= sat32(64'(rate_r) - 64'(bias_r));
          pd0_r   <= sat32(64'({1'b0, qa_r}) - 64'(p01_r) - 64'(p10_r));
          pd1_r   <= sat32(-64'(p11_r));
          op_r    <= OP_ANG_PRED;
          state_r <= ST_ISSUE;
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (mac_done) begin
            state_r <= ST_ISSUE;
            op_r    <= op_t'(op_r + 4'd1);
            case (op_r)
              OP_ANG_PRED: begin
                ang_r <= mac_res;
                err_r <= sat32(64'(meas_r) - 64'(mac_res));
              end
              OP_P00_PRED, OP_P00_CORR: p00_r <= mac_res;
              OP_P01_PRED, OP_P01_CORR: p01_r <= mac_res;
              OP_P10_PRED, OP_P10_CORR: p10_r <= mac_res;
              OP_P11_PRED: begin
                p11_r   <= mac_res;
                state_r <= ST_DIV_SET;
              end
              OP_P11_CORR: p11_r <= mac_res;
              OP_ANG_CORR: ang_r <= mac_res;
              OP_BIAS_CORR: begin
                bias_r  <= mac_res;
                state_r <= ST_FINISH;
              end
              default: ;
            endcase
          end
        end
        ST_DIV_SET: begin
          t0_r <= p00_r;
          t1_r <= p01_r;
          e_r  <= e_sum[31:0];
          if (e_pos) begin
            state_r <= ST_DIV0;
          end else begin
            // no usable innovation variance: gains drop to zero
            k0_r    <= '0;
            k1_r    <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_DIV0: begin
          if (div_done) begin
            k0_r    <= div_quo;
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            k1_r    <= div_quo;
            state_r <= ST_ISSUE;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_ang_r   <= (ang_w > ANG_LIM) ? 25'(ANG_LIM) :
                           (ang_w < -ANG_LIM) ? 25'(-ANG_LIM) : ang_r[24:0];
            out_rate_r  <= (rate_w > RATE_LIM) ? 28'(RATE_LIM) :
                           (rate_w < -RATE_LIM) ? 28'(-RATE_LIM) : rate_w[27:0];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_ang_r;
  assign out_filtered_rate  = out_rate_r;

endmodule

>>> rtl/tak_chk.sv
// ----------------------------------------------------------------------------
// tak_chk
// Port-level checks for the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
module tak_chk #(
  parameter int DATA_FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [24:0] out_filtered_angle,
  input logic signed [27:0] out_filtered_rate
);

  localparam longint ALIM_RAW = 64'sd180 <<< DATA_FRAC_BITS;
  localparam logic signed [24:0] ALIM =
    (ALIM_RAW < 64'sd16777215) ? 25'(ALIM_RAW) : 25'sd16777215;

  // one sample in flight: take a beat, then drop ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after a beat");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_filtered_angle)
      && $stable(out_filtered_rate)))
    else $error("stalled result changed");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_filtered_angle <= ALIM && out_filtered_angle >= -ALIM))
    else $error("filtered angle outside saturation range");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind tilt_angle_kalman_filter tak_chk #(.DATA_FRAC_BITS(DATA_FRAC_BITS)) u_tak_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_angle (out_filtered_angle),
  .out_filtered_rate  (out_filtered_rate)
);
